FILE: src/sda_pkg.sv
// Shared constants and types for the signed integer to decimal text converter.
package sda_pkg;

    // Input and output field widths.
    localparam int VALUE_W = 32;
    localparam int CHAR_W  = 8;

    // Ten decimal digits cover every 32-bit magnitude, including 2147483648.
    localparam int BCD_DIGITS = 10;
    localparam int BCD_W      = 4 * BCD_DIGITS;
    localparam int DIGIT_IDX_W = 4;

    // Shift-and-add-3 conversion: one input bit per step, eight steps per stage.
    localparam int DABBLE_STEPS  = 8;
    localparam int DABBLE_STAGES = VALUE_W / DABBLE_STEPS;

    // ASCII codes.
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'd48;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'd45;

    // Work item carried down the conversion pipeline.
    typedef struct packed {
        logic [BCD_W-1:0]   bcd;
        logic [VALUE_W-1:0] bits;
        logic               neg;
    } sda_work_t;

endpackage

FILE: src/sda_dabble_stage.sv
// One pipeline stage that folds eight magnitude bits into the BCD accumulator.
module sda_dabble_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  logic              valid_in,
    input  sda_pkg::sda_work_t work_in,
    output logic              valid_out,
    output sda_pkg::sda_work_t work_out
);
    import sda_pkg::*;

    logic [BCD_W-1:0]   bcd_work;
    logic [VALUE_W-1:0] bits_work;
    logic               valid_reg;
    sda_work_t          work_reg;
    sda_work_t          work_next;

    // Eight shift-and-add-3 steps, most significant magnitude bit first.
    always_comb
    begin
        bcd_work  = work_in.bcd;
        bits_work = work_in.bits;
        for (int s = 0; s < DABBLE_STEPS; s++)
        begin
            for (int d = 0; d < BCD_DIGITS; d++)
            begin
                if (bcd_work[d*4 +: 4] >= 4'd5)
                begin
                    bcd_work[d*4 +: 4] = bcd_work[d*4 +: 4] + 4'd3;
                end
            end
            bcd_work  = {bcd_work[BCD_W-2:0], bits_work[VALUE_W-1]};
            bits_work = {bits_work[VALUE_W-2:0], 1'b0};
        end
        work_next.bcd  = bcd_work;
        work_next.bits = bits_work;
        work_next.neg  = work_in.neg;
    end

    // The valid bit travels with the data and moves only when the pipeline advances.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= valid_in;
        end
    end

    // Payload register.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            work_reg <= work_next;
        end
    end

    assign valid_out = valid_reg;
    assign work_out  = work_reg;

endmodule

FILE: src/sda_serializer.sv
// Output stage that turns a converted BCD value into one ASCII character per transaction.
module sda_serializer (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         work_valid,
    input  sda_pkg::sda_work_t           work,
    output logic                         work_take,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [sda_pkg::CHAR_W-1:0]   char_code,
    output logic                         is_last
);
    import sda_pkg::*;

    logic                   valid_reg, valid_next;
    logic                   have_reg, have_next;
    logic                   minus_reg, minus_next;
    logic [DIGIT_IDX_W-1:0] idx_reg, idx_next;
    logic [BCD_W-1:0]       bcd_reg, bcd_next;
    logic [CHAR_W-1:0]      char_reg, char_next;
    logic                   last_reg, last_next;
    logic                   out_free;
    logic [DIGIT_IDX_W-1:0] msd;
    logic [3:0]             held_digit;
    logic [3:0]             new_digit;

    // Position of the most significant nonzero digit; zero maps to digit 0.
    always_comb
    begin
        msd = '0;
        for (int d = 0; d < BCD_DIGITS; d++)
        begin
            if (work.bcd[d*4 +: 4] != 4'd0)
            begin
                msd = DIGIT_IDX_W'(d);
            end
        end
    end

    assign held_digit = bcd_reg[{idx_reg, 2'b00} +: 4];
    assign new_digit  = work.bcd[{msd, 2'b00} +: 4];
    assign out_free   = !valid_reg || !out_stall;
    assign work_take  = out_free && !have_reg && work_valid;

    // Next character: continue the held number, or start the next one.
    always_comb
    begin
        valid_next = valid_reg;
        have_next  = have_reg;
        minus_next = minus_reg;
        idx_next   = idx_reg;
        bcd_next   = bcd_reg;
        char_next  = char_reg;
        last_next  = last_reg;
        if (out_free)
        begin
            priority if (have_reg)
            begin
                valid_next = 1'b1;
                if (minus_reg)
                begin
                    char_next  = CHAR_MINUS;
                    last_next  = 1'b0;
                    minus_next = 1'b0;
                end
                else
                begin
                    char_next = CHAR_ZERO + {4'd0, held_digit};
                    last_next = (idx_reg == '0);
                    if (idx_reg == '0)
                    begin
                        have_next = 1'b0;
                    end
                    else
                    begin
                        idx_next = idx_reg - 1'b1;
                    end
                end
            end
            else if (work_valid)
            begin
                valid_next = 1'b1;
                bcd_next   = work.bcd;
                minus_next = 1'b0;
                if (work.neg)
                begin
                    char_next = CHAR_MINUS;
                    last_next = 1'b0;
                    have_next = 1'b1;
                    idx_next  = msd;
                end
                else
                begin
                    char_next = CHAR_ZERO + {4'd0, new_digit};
                    last_next = (msd == '0);
                    have_next = (msd != '0);
                    idx_next  = msd - 1'b1;
                end
            end
            else
            begin
                valid_next = 1'b0;
            end
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            have_reg  <= 1'b0;
            minus_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            have_reg  <= have_next;
            minus_reg <= minus_next;
            idx_reg   <= idx_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        bcd_reg  <= bcd_next;
        char_reg <= char_next;
        last_reg <= last_next;
    end

    assign out_valid = valid_reg;
    assign char_code = char_reg;
    assign is_last   = last_reg;

    // A number still in progress always has a character on the output.
    assert property (@(posedge clk) disable iff (!rst_n) have_reg |-> valid_reg)
        else $error("number in progress without a valid output character");

    // The last character closes the number being emitted.
    assert property (@(posedge clk) disable iff (!rst_n) (valid_reg && last_reg) |-> !have_reg)
        else $error("last flag raised while digits remain");

    // A minus sign is never the final character.
    assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && char_reg == CHAR_MINUS) |-> !last_reg)
        else $error("minus sign flagged as last character");

    // The digit pointer stays within the ten BCD digits.
    assert property (@(posedge clk) disable iff (!rst_n) have_reg |-> (idx_reg < 4'd10))
        else $error("digit index out of range");

endmodule

FILE: src/signed_int_to_decimal_ascii.sv
// Top level of the signed 32-bit integer to decimal ASCII text converter.
//
// Input channel: in_valid, in_stall and value carry one signed 32-bit integer
// per transaction. Output channel: out_valid, out_stall, char_code and is_last
// carry one ASCII character per transaction, most significant first, with a
// leading '-' for negative values and is_last set on the final digit.
// An input transaction enters a pipeline of one input register and four
// conversion stages (eight shift-and-add-3 steps each), then an output
// register that emits the characters. Throughput: one character per cycle at
// the output while out_stall is low, with 1 to 11 characters per number. The
// pipeline accepts one value per cycle while the output stage keeps up; when a
// finished value waits for the output stage, the whole pipeline holds and
// in_stall is raised.
// When the receiver raises out_stall, the current character holds on the
// output and the pipeline fills up behind it; nothing is lost or repeated.
// Reset clears all valid bits: no character is pending and the input is ready.
module signed_int_to_decimal_ascii (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic signed [sda_pkg::VALUE_W-1:0] value,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [sda_pkg::CHAR_W-1:0]        char_code,
    output logic                              is_last
);
    import sda_pkg::*;

    logic [DABBLE_STAGES:0] stage_valid;
    sda_work_t              stage_work [DABBLE_STAGES+1];
    logic                   advance;
    logic                   work_take;
    logic                   valid0_reg;
    sda_work_t              work0_reg;
    sda_work_t              work0_next;
    logic [VALUE_W-1:0]     value_bits;

    // The pipeline moves when its last stage is empty or handed to the output.
    assign advance  = !stage_valid[DABBLE_STAGES] || work_take;
    assign in_stall = !advance;

    // Input stage: sign and magnitude; the most negative value stays 2^31 unsigned.
    assign value_bits      = $unsigned(value);
    assign work0_next.neg  = value_bits[VALUE_W-1];
    assign work0_next.bits = value_bits[VALUE_W-1] ? (~value_bits + 1'b1) : value_bits;
    assign work0_next.bcd  = '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid0_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid0_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            work0_reg <= work0_next;
        end
    end

    assign stage_valid[0] = valid0_reg;
    assign stage_work[0]  = work0_reg;

    // Conversion stages.
    for (genvar g = 0; g < DABBLE_STAGES; g++)
    begin : g_dabble
        sda_dabble_stage u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .advance   (advance),
            .valid_in  (stage_valid[g]),
            .work_in   (stage_work[g]),
            .valid_out (stage_valid[g+1]),
            .work_out  (stage_work[g+1])
        );
    end

    // Character output stage.
    sda_serializer u_serializer (
        .clk        (clk),
        .rst_n      (rst_n),
        .work_valid (stage_valid[DABBLE_STAGES]),
        .work       (stage_work[DABBLE_STAGES]),
        .work_take  (work_take),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .char_code  (char_code),
        .is_last    (is_last)
    );

endmodule

FILE: test/signed_int_to_decimal_ascii_test.sv
`timescale 1ns / 1ps
// Testbench for the signed 32-bit integer to decimal ASCII text converter.
module signed_int_to_decimal_ascii_test;

    import sda_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 24;
    localparam int RANDOM_ITEMS = 111;

    // One expected output character.
    typedef struct packed {
        logic [CHAR_W-1:0] code;
        logic              last;
    } text_char_t;

    logic                       clk = 1'b0;
    logic                       rst_n;
    logic                       in_valid;
    logic                       in_stall;
    logic signed [VALUE_W-1:0]  value;
    logic                       out_valid;
    logic                       out_stall = 1'b0;
    logic [CHAR_W-1:0]          char_code;
    logic                       is_last;

    text_char_t                 pending_text[$];
    text_char_t                 next_char;
    int                         error_count = 0;
    int                         cycle_count = 0;
    int                         burst_left = 0;
    int                         stall_mode = 0;
    int                         stall_phase = 0;

    signed_int_to_decimal_ascii dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .value     (value),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .char_code (char_code),
        .is_last   (is_last)
    );

    // Clock with a 10 ns period.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Print one mismatch line and count it.
    task automatic report_mismatch(input string msg);
        $display("mismatch at cycle %0d: %s", cycle_count, msg);
        error_count++;
    endtask

    // Work out the decimal text of one value and queue its characters.
    function automatic void push_decimal_text(input logic signed [VALUE_W-1:0] number);
        logic [VALUE_W-1:0] magnitude;
        logic [3:0]         digit_stack [BCD_DIGITS];
        int                 digit_count;
        text_char_t         item;

        // The most negative value wraps back to 2^31 in unsigned arithmetic.
        magnitude = number[VALUE_W-1] ? (VALUE_W'(0) - VALUE_W'(number)) : VALUE_W'(number);
        digit_count = 0;
        do
        begin
            digit_stack[digit_count] = 4'(magnitude % 10);
            magnitude = magnitude / 10;
            digit_count++;
        end
        while (magnitude != 0);

        if (number[VALUE_W-1])
        begin
            item.code = CHAR_MINUS;
            item.last = 1'b0;
            pending_text.push_back(item);
        end
        for (int i = digit_count - 1; i >= 0; i--)
        begin
            item.code = CHAR_ZERO + CHAR_W'(digit_stack[i]);
            item.last = (i == 0);
            pending_text.push_back(item);
        end
    endfunction

    // Send one value, with random gaps between bursts of transactions.
    task automatic send_value(input logic signed [VALUE_W-1:0] number);
        if (burst_left == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(15, 30)
                                                     : $urandom_range(1, 8);
        end
        in_valid <= 1'b1;
        value    <= number;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        push_decimal_text(number);
        burst_left--;
    endtask

    // Random value drawn from several shapes: full range, small, random width, near the ends.
    function automatic logic signed [VALUE_W-1:0] random_value();
        logic [VALUE_W-1:0] magnitude;
        int                 width;

        case ($urandom_range(0, 3))
            0: random_value = $urandom;
            1:
            begin
                magnitude = $urandom_range(0, 99);
                random_value = $urandom_range(0, 1) ? -$signed(magnitude) : $signed(magnitude);
            end
            2:
            begin
                width = $urandom_range(1, VALUE_W - 1);
                magnitude = $urandom & ((VALUE_W'(1) << width) - 1);
                random_value = $urandom_range(0, 1) ? -$signed(magnitude) : $signed(magnitude);
            end
            default:
            begin
                if ($urandom_range(0, 1))
                    random_value = 32'h8000_0000 + $urandom_range(0, 3);
                else
                    random_value = 32'h7fff_ffff - $urandom_range(0, 3);
            end
        endcase
    endfunction

    // Zero and single-digit values of both signs.
    task automatic test_short_text();
        send_value(0);
        send_value(1);
        send_value(9);
        send_value(-1);
        send_value(-9);
    endtask

    // Ends of the range, including the most negative value with eleven characters.
    task automatic test_range_ends();
        send_value(32'sh7fff_ffff);
        send_value(32'sh8000_0000);
        send_value(32'sh8000_0001);
        send_value(32'shffff_fffe);
    endtask

    // Values around powers of ten, where the digit count changes.
    task automatic test_digit_count_edges();
        send_value(10);
        send_value(-10);
        send_value(99);
        send_value(100);
        send_value(-999);
        send_value(1000000000);
        send_value(-1000000000);
        send_value(999999999);
        send_value(-999999999);
        send_value(1000000);
    endtask

    // Random values over the whole range.
    task automatic test_random_values();
        for (int n = 0; n < RANDOM_ITEMS; n++)
            send_value(random_value());
    endtask

    // Compare each character transaction with the oldest expected character.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_text.size() == 0)
                report_mismatch($sformatf("unexpected character 0x%02h", char_code));
            else
            begin
                next_char = pending_text.pop_front();
                if (char_code !== next_char.code)
                    report_mismatch($sformatf("char_code 0x%02h, wanted 0x%02h",
                                              char_code, next_char.code));
                if (is_last !== next_char.last)
                    report_mismatch($sformatf("is_last %b, wanted %b",
                                              is_last, next_char.last));
            end
        end
    end

    // Receiver stall pattern: a new random mode is drawn whenever the phase counter wraps.
    always @(posedge clk)
    begin
        if (stall_phase == 49)
        begin
            stall_phase <= 0;
            stall_mode  <= $urandom_range(0, 3);
        end
        else
            stall_phase <= stall_phase + 1;

        case (stall_mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 2) == 0);
            2: out_stall <= stall_phase[0];
            default: out_stall <= ((stall_phase % 16) < 10);
        endcase
    end

    // Cycle counter that ends a hung run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Reset, then run the tests in turn and drain the output.
    initial
    begin
        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        value    <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_short_text();
        test_range_ends();
        test_digit_count_edges();
        test_random_values();
        in_valid <= 1'b0;

        while (pending_text.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
